/* rtl/tbut_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Timer-based UART transceiver package
// Shared widths, register indexes, reset values, status types and the tick
// counter step used by both the transmitter and the receiver.
// ----------------------------------------------------------------------------
package tbut_pkg;

   localparam int CNT_W      = 16;
   localparam int PERIOD_W   = 16;
   localparam int HALF_W     = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CMP_W      = ((CNT_W > PERIOD_W) ? CNT_W : PERIOD_W) + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_BIT_PERIOD = CSR_IDX_W'(1);

   localparam int CLOCK_HZ = 1000000;
   localparam int BAUD     = 9600;

   localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST      = PERIOD_W'(CLOCK_HZ / BAUD);
   localparam logic [HALF_W-1:0]   HALF_BIT_PERIOD_RST = HALF_W'(CLOCK_HZ / (BAUD * 2));

   localparam logic [3:0] FRAME_BITS = 4'd10;
   localparam logic [3:0] DATA_BITS  = 4'd8;
   localparam logic [3:0] HALF_PHASE = 4'd9;

   typedef struct packed {
      logic [PERIOD_W-1:0] bit_period;
      logic [HALF_W-1:0]   half_bit_period;
   } cfg_type;

   typedef struct packed {
      logic             expired;
      logic [CNT_W-1:0] count;
   } tick_type;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } rx_status_type;

   // Advances a bit timer by one tick. The interval expires once the count
   // reaches the period without wrapping, or at once for a period of 0 or 1.
   function automatic tick_type tick_step(input logic [CNT_W-1:0]    count,
                                          input logic [PERIOD_W-1:0] period);
      logic [CMP_W-1:0] inc;
      tick_type         r;
      inc = CMP_W'(count) + CMP_W'(1);
      if ((inc >= CMP_W'(period)) && (count != {CNT_W{1'b1}})) begin
         r.expired = 1'b1;
         r.count   = '0;
      end else if (period <= PERIOD_W'(1)) begin
         r.expired = 1'b1;
         r.count   = '0;
      end else begin
         r.expired = 1'b0;
         r.count   = inc[CNT_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/timer_based_uart_transceiver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Timer-based UART transceiver (8N1)
// Each request word is one timer tick carrying the receive line level and an
// optional byte to send. Each response word gives the transmit line level,
// the transmitter busy flag, a received-byte strobe and the last byte
// received.
// The request and response channels use valid and stall. A response word
// appears in the cycle after its request word is accepted, and one request word
// is taken in every cycle, limited only by the single output register. When
// the response side stalls with a word waiting, req_stall rises in the same
// cycle and the state holds; the bit timers move only on accepted words.
// The configuration channel (valid and ready, always ready) writes the bit
// period and half bit period; writes to other indexes are ignored.
// Reset (synchronous) returns both bit timers to idle, the line to the idle
// level, the registers to 104 and 52 and empties the output register.
// ----------------------------------------------------------------------------
module timer_based_uart_transceiver (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_rx_level,
   input  wire logic                                req_send_request,
   input  wire logic [7:0]                          req_send_byte,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_tx_level,
   output      logic                                rsp_tx_busy,
   output      logic                                rsp_rx_valid,
   output      logic [7:0]                          rsp_rx_byte,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [tbut_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tbut_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tbut_pkg::cfg_type       cfg_ff;
   tbut_pkg::tx_status_type tx_status;
   tbut_pkg::rx_status_type rx_status;
   logic                    advance;
   logic                    rsp_valid_ff;
   logic                    tx_level_ff;
   logic                    tx_busy_ff;
   logic                    rx_valid_ff;
   logic [7:0]              rx_byte_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period      <= tbut_pkg::BIT_PERIOD_RST;
         cfg_ff.half_bit_period <= tbut_pkg::HALF_BIT_PERIOD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tbut_pkg::CSR_BIT_PERIOD: begin
               cfg_ff.bit_period <= csr_wdata[tbut_pkg::PERIOD_W-1:0];
            end
            tbut_pkg::CSR_HALF_BIT_PERIOD: begin
               cfg_ff.half_bit_period <= csr_wdata[tbut_pkg::HALF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign advance   = req_valid && !req_stall;

   tbut_tx u_tx (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cfg          (cfg_ff),
      .send_request (req_send_request),
      .send_byte    (req_send_byte),
      .status       (tx_status)
   );

   tbut_rx u_rx (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cfg      (cfg_ff),
      .rx_level (req_rx_level),
      .status   (rx_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tx_level_ff <= tx_status.line;
         tx_busy_ff  <= tx_status.busy;
         rx_valid_ff <= rx_status.valid;
         rx_byte_ff  <= rx_status.data;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tx_level = tx_level_ff;
   assign rsp_tx_busy  = tx_busy_ff;
   assign rsp_rx_valid = rx_valid_ff;
   assign rsp_rx_byte  = rx_byte_ff;

   // Every accepted request word leaves a response word waiting.
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   // The request side is held back only by a waiting, stalled response.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid_ff)
      else $error("request stalled with empty output register");

endmodule
`default_nettype wire

/* rtl/tbut_tx.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// UART transmitter
// Frames a byte as start bit, eight data bits LSB first and stop bit, one
// bit time per bit after an initial idle bit time. Advances once per word.
// ----------------------------------------------------------------------------
module tbut_tx (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire tbut_pkg::cfg_type      cfg,
   input  wire logic                   send_request,
   input  wire logic [7:0]             send_byte,
   output tbut_pkg::tx_status_type     status
);

   logic [9:0]                 shift_ff, shift_in;
   logic [3:0]                 bits_ff, bits_in;
   logic [tbut_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       active_ff, active_in;
   logic                       line_ff, line_in;
   tbut_pkg::tick_type         tick;

   always_comb begin
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      line_in   = line_ff;
      tick      = tbut_pkg::tick_step(cnt_ff, cfg.bit_period);
      if (active_ff) begin
         cnt_in = tick.count;
         if (tick.expired) begin
            if (bits_ff == 4'd0) begin
               active_in = 1'b0;
               bits_in   = tbut_pkg::FRAME_BITS;
            end else begin
               line_in  = shift_ff[0];
               shift_in = {1'b0, shift_ff[9:1]};
               bits_in  = bits_ff - 4'd1;
            end
         end
      end else if (send_request) begin
         shift_in  = {1'b1, send_byte, 1'b0};
         bits_in   = tbut_pkg::FRAME_BITS;
         cnt_in    = '0;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= '1;
         bits_ff   <= tbut_pkg::FRAME_BITS;
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         line_ff   <= 1'b1;
      end else if (advance) begin
         shift_ff  <= shift_in;
         bits_ff   <= bits_in;
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
         line_ff   <= line_in;
      end
   end

   assign status.line = line_in;
   assign status.busy = active_in;

   // An idle transmitter always rests on the stop level.
   assert property (@(posedge clock) disable iff (reset) !active_ff |-> line_ff)
      else $error("tx line low while idle");

   assert property (@(posedge clock) disable iff (reset) bits_ff <= tbut_pkg::FRAME_BITS)
      else $error("tx bit count out of range");

endmodule
`default_nettype wire

/* rtl/tbut_rx.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// UART receiver
// Hunts for a falling edge, waits half a bit plus one bit, then samples eight
// data bits LSB first at one bit time apart. Advances once per word.
// ----------------------------------------------------------------------------
module tbut_rx (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire tbut_pkg::cfg_type      cfg,
   input  wire logic                   rx_level,
   output tbut_pkg::rx_status_type     status
);

   logic                       hunting_ff, hunting_in;
   logic                       prev_ff;
   logic [tbut_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                 shift_ff, shift_in;
   logic [3:0]                 bits_ff, bits_in;
   logic [3:0]                 bits_dec;
   logic [7:0]                 last_ff, last_in;
   logic                       valid;
   tbut_pkg::tick_type         tick_half;
   tbut_pkg::tick_type         tick_bit;

   always_comb begin
      hunting_in = hunting_ff;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      bits_in    = bits_ff;
      last_in    = last_ff;
      valid      = 1'b0;
      bits_dec   = bits_ff - 4'd1;
      tick_half  = tbut_pkg::tick_step(cnt_ff,
                      tbut_pkg::PERIOD_W'(cfg.half_bit_period));
      tick_bit   = tbut_pkg::tick_step(cnt_ff, cfg.bit_period);
      if (hunting_ff) begin
         if (prev_ff && !rx_level) begin
            hunting_in = 1'b0;
            cnt_in     = '0;
            bits_in    = tbut_pkg::HALF_PHASE;
         end
      end else if (bits_ff == tbut_pkg::HALF_PHASE) begin
         cnt_in = tick_half.count;
         if (tick_half.expired) begin
            bits_in = tbut_pkg::DATA_BITS;
         end
      end else begin
         cnt_in = tick_bit.count;
         if (tick_bit.expired) begin
            shift_in = {rx_level, shift_ff[7:1]};
            bits_in  = bits_dec;
            if ((bits_dec == 4'd0) || (bits_dec > tbut_pkg::DATA_BITS)) begin
               last_in    = shift_in;
               valid      = 1'b1;
               bits_in    = tbut_pkg::DATA_BITS;
               hunting_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff <= 1'b1;
         prev_ff    <= 1'b1;
         cnt_ff     <= '0;
         shift_ff   <= '0;
         bits_ff    <= tbut_pkg::DATA_BITS;
         last_ff    <= '0;
      end else if (advance) begin
         hunting_ff <= hunting_in;
         prev_ff    <= rx_level;
         cnt_ff     <= cnt_in;
         shift_ff   <= shift_in;
         bits_ff    <= bits_in;
         last_ff    <= last_in;
      end
   end

   assign status.valid = valid;
   assign status.data  = last_in;

   // A completed byte always returns the receiver to hunting.
   assert property (@(posedge clock) disable iff (reset) advance && valid |=> hunting_ff)
      else $error("rx not hunting after a completed byte");

   assert property (@(posedge clock) disable iff (reset)
                    hunting_ff |-> bits_ff == tbut_pkg::DATA_BITS)
      else $error("rx bit count not reloaded while hunting");

endmodule
`default_nettype wire

/* test/timer_based_uart_transceiver_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer-based UART transceiver testbench
// Each request word is one timer tick. The tick words carry serial frames on
// the receive line and random send requests. The bench predicts every
// response word, field by field, and checks it. The bench runs a short
// scripted sequence first. Then come random phases with different bit
// periods, including the extremes. Both handshakes are held off at random.
// ----------------------------------------------------------------------------
module timer_based_uart_transceiver_test;

   localparam logic [tbut_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = tbut_pkg::CSR_IDX_W'(2);
   localparam logic [tbut_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = tbut_pkg::CSR_IDX_W'(3);
   localparam int STUCK_LIMIT = 2000;
   localparam int LONG_HOLD   = 120;
   localparam int NUM_PHASES  = 12;

   typedef struct packed {
      logic       tx_level;
      logic       tx_busy;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } line_word_type;

   typedef struct packed {
      logic                       done;
      logic [tbut_pkg::CNT_W-1:0] count;
   } timer_result_type;

   typedef struct packed {
      logic                            is_write;
      logic [tbut_pkg::CSR_IDX_W-1:0]  index;
      logic [tbut_pkg::CSR_DATA_W-1:0] value;
      logic                            lvl;
      logic                            req;
      logic [7:0]                      data;
      logic                            typed;
      line_word_type                   want;
   } script_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_rx_level = 1'b1;
   logic                            req_send_request = 1'b0;
   logic [7:0]                      req_send_byte = 8'h00;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_tx_level;
   logic                            rsp_tx_busy;
   logic                            rsp_rx_valid;
   logic [7:0]                      rsp_rx_byte;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [tbut_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [tbut_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Predicted transceiver state and registers.
   logic [tbut_pkg::PERIOD_W-1:0]   cfg_period;
   logic [tbut_pkg::HALF_W-1:0]     cfg_half;
   logic [9:0]                      tx_frame;
   logic [3:0]                      tx_left;
   logic [tbut_pkg::CNT_W-1:0]      tx_ticks;
   logic                            tx_on;
   logic                            tx_out;
   logic                            rx_idle;
   logic                            rx_last_lvl;
   logic [tbut_pkg::CNT_W-1:0]      rx_ticks;
   logic [7:0]                      rx_acc;
   logic [3:0]                      rx_left;
   logic [7:0]                      rx_held;

   line_word_type         pending_lines[$];
   logic                  rx_pattern[$];
   script_row_type        script[22];

   bit                    no_gaps = 1'b0;
   bit                    hold_long = 1'b0;
   int unsigned           failures = 0;
   int unsigned           words_sent = 0;
   int unsigned           frames_taken = 0;
   int unsigned           bytes_seen = 0;
   int unsigned           settings_used = 0;
   int unsigned           stuck_cycles = 0;

   timer_based_uart_transceiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_level     (req_rx_level),
      .req_send_request (req_send_request),
      .req_send_byte    (req_send_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_level     (rsp_tx_level),
      .rsp_tx_busy      (rsp_tx_busy),
      .rsp_rx_valid     (rsp_rx_valid),
      .rsp_rx_byte      (rsp_rx_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic timer_result_type run_timer(
         input logic [tbut_pkg::CNT_W-1:0]    count,
         input logic [tbut_pkg::PERIOD_W-1:0] period);
      int unsigned      next_count;
      timer_result_type r;
      next_count = count + 1;
      if ((next_count >= period) && (next_count < (32'd1 << tbut_pkg::CNT_W))) begin
         r.done  = 1'b1;
         r.count = '0;
      end else if (period <= 1) begin
         r.done  = 1'b1;
         r.count = '0;
      end else begin
         r.done  = 1'b0;
         r.count = next_count[tbut_pkg::CNT_W-1:0];
      end
      return r;
   endfunction

   function automatic void clear_line_state();
      cfg_period  = tbut_pkg::BIT_PERIOD_RST;
      cfg_half    = tbut_pkg::HALF_BIT_PERIOD_RST;
      tx_frame    = '1;
      tx_left     = tbut_pkg::FRAME_BITS;
      tx_ticks    = '0;
      tx_on       = 1'b0;
      tx_out      = 1'b1;
      rx_idle     = 1'b1;
      rx_last_lvl = 1'b1;
      rx_ticks    = '0;
      rx_acc      = '0;
      rx_left     = tbut_pkg::DATA_BITS;
      rx_held     = '0;
   endfunction

   function automatic line_word_type predict_line(input logic lvl, input logic req,
                                                  input logic [7:0] data);
      timer_result_type t;
      line_word_type    w;
      w.rx_valid = 1'b0;
      if (tx_on) begin
         t = run_timer(tx_ticks, cfg_period);
         tx_ticks = t.count;
         if (t.done) begin
            if (tx_left == 4'd0) begin
               tx_on   = 1'b0;
               tx_left = tbut_pkg::FRAME_BITS;
            end else begin
               tx_out   = tx_frame[0];
               tx_frame = tx_frame >> 1;
               tx_left  = tx_left - 4'd1;
            end
         end
      end else if (req) begin
         tx_frame = {1'b1, data, 1'b0};
         tx_left  = tbut_pkg::FRAME_BITS;
         tx_ticks = '0;
         tx_on    = 1'b1;
         frames_taken++;
      end
      if (rx_idle) begin
         if (rx_last_lvl && !lvl) begin
            rx_idle  = 1'b0;
            rx_ticks = '0;
            rx_left  = tbut_pkg::HALF_PHASE;
         end
      end else if (rx_left == tbut_pkg::HALF_PHASE) begin
         t = run_timer(rx_ticks, tbut_pkg::PERIOD_W'(cfg_half));
         rx_ticks = t.count;
         if (t.done) rx_left = tbut_pkg::DATA_BITS;
      end else begin
         t = run_timer(rx_ticks, cfg_period);
         rx_ticks = t.count;
         if (t.done) begin
            rx_acc  = {lvl, rx_acc[7:1]};
            rx_left = rx_left - 4'd1;
            if ((rx_left == 4'd0) || (rx_left > tbut_pkg::DATA_BITS)) begin
               rx_held    = rx_acc;
               w.rx_valid = 1'b1;
               rx_left    = tbut_pkg::DATA_BITS;
               rx_idle    = 1'b1;
            end
         end
      end
      rx_last_lvl = lvl;
      w.tx_level  = tx_out;
      w.tx_busy   = tx_on;
      w.rx_byte   = rx_held;
      return w;
   endfunction

   function automatic script_row_type tick(input logic lvl, input logic req,
                                           input logic [7:0] data, input logic typed,
                                           input line_word_type want);
      script_row_type r;
      r = '0;
      r.lvl   = lvl;
      r.req   = req;
      r.data  = data;
      r.typed = typed;
      r.want  = want;
      return r;
   endfunction

   function automatic script_row_type reg_write(
         input logic [tbut_pkg::CSR_IDX_W-1:0]  index,
         input logic [tbut_pkg::CSR_DATA_W-1:0] value);
      script_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.index    = index;
      r.value    = value;
      return r;
   endfunction

   task automatic send_tick(input logic lvl, input logic req, input logic [7:0] data,
                            input logic typed, input line_word_type want);
      int unsigned   gap;
      line_word_type got;
      gap = no_gaps ? 0 : $urandom_range(14, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_rx_level     <= lvl;
      req_send_request <= req;
      req_send_byte    <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = predict_line(lvl, req, data);
      pending_lines.push_back(typed ? want : got);
      words_sent++;
   endtask

   task automatic write_csr(input logic [tbut_pkg::CSR_IDX_W-1:0]  index,
                            input logic [tbut_pkg::CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == tbut_pkg::CSR_BIT_PERIOD) cfg_period = value;
      else if (index == tbut_pkg::CSR_HALF_BIT_PERIOD) cfg_half = value[tbut_pkg::HALF_W-1:0];
      csr_valid <= 1'b0;
   endtask

   // Appends receive line levels: mostly whole frames, sometimes a frame that
   // stops short, sometimes a burst of noise.
   task automatic queue_rx_pattern(input int unsigned width, input bit noise_only);
      int unsigned pick;
      int unsigned nbits;
      int unsigned b;
      logic [9:0]  frame;
      pick  = noise_only ? 9 : $urandom_range(9, 0);
      frame = {1'b1, 8'($urandom_range(255, 0)), 1'b0};
      if (pick >= 8) begin
         repeat ($urandom_range(6, 1)) rx_pattern.push_back(1'($urandom_range(1, 0)));
      end else begin
         repeat ($urandom_range(4, 0)) rx_pattern.push_back(1'b1);
         nbits = (pick == 7) ? $urandom_range(8, 1) : 10;
         for (b = 0; b < nbits; b++) begin
            repeat (width) rx_pattern.push_back(frame[b]);
         end
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         failures++;
         if (failures <= 20)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_responses
      line_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lines.size() == 0) begin
            failures++;
            if (failures <= 20)
               $display("%0t: response word with nothing expected, expected none, actual %h",
                        $time, {rsp_tx_level, rsp_tx_busy, rsp_rx_valid, rsp_rx_byte});
         end else begin
            want = pending_lines.pop_front();
            compare_field("tx_level", 32'(want.tx_level), 32'(rsp_tx_level));
            compare_field("tx_busy", 32'(want.tx_busy), 32'(rsp_tx_busy));
            compare_field("rx_valid", 32'(want.rx_valid), 32'(rsp_rx_valid));
            compare_field("rx_byte", 32'(want.rx_byte), 32'(rsp_rx_byte));
            if (want.rx_valid) bytes_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, stuck_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : drive_response_stall
      int unsigned hold;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else begin
            hold = no_gaps ? 0 : $urandom_range(14, 0);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   initial begin : drive_ticks
      script_row_type                  row;
      logic [tbut_pkg::PERIOD_W-1:0]   period;
      logic [tbut_pkg::CSR_DATA_W-1:0] half;
      int unsigned                     items;
      int unsigned                     width;
      int                              phase;
      clear_line_state();
      script[0]  = tick(1'b1, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00});
      script[1]  = tick(1'b1, 1'b1, 8'hA5, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h00});
      script[2]  = tick(1'b1, 1'b1, 8'h5A, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h00});
      script[3]  = tick(1'b0, 1'b0, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0, 8'h00});
      script[4]  = reg_write(tbut_pkg::CSR_BIT_PERIOD, 16'd1);
      script[5]  = reg_write(tbut_pkg::CSR_HALF_BIT_PERIOD, 16'd0);
      script[6]  = tick(1'b0, 1'b0, 8'h00, 1'b0, '0);
      script[7]  = tick(1'b1, 1'b0, 8'h00, 1'b0, '0);
      script[8]  = tick(1'b1, 1'b0, 8'h00, 1'b0, '0);
      script[9]  = tick(1'b0, 1'b0, 8'h00, 1'b0, '0);
      script[10] = tick(1'b0, 1'b1, 8'hFF, 1'b0, '0);
      script[11] = tick(1'b1, 1'b0, 8'h00, 1'b0, '0);
      script[12] = tick(1'b1, 1'b0, 8'h00, 1'b0, '0);
      script[13] = tick(1'b0, 1'b0, 8'h00, 1'b0, '0);
      script[14] = tick(1'b1, 1'b0, 8'h00, 1'b0, '0);
      script[15] = tick(1'b0, 1'b0, 8'h00, 1'b0, '0);
      script[16] = reg_write(tbut_pkg::CSR_BIT_PERIOD, 16'hFFFF);
      script[17] = reg_write(tbut_pkg::CSR_HALF_BIT_PERIOD, 16'hFFFF);
      script[18] = tick(1'b1, 1'b1, 8'h00, 1'b0, '0);
      script[19] = tick(1'b1, 1'b1, 8'hFF, 1'b0, '0);
      script[20] = reg_write(CSR_UNUSED_LO, 16'hFFFF);
      script[21] = tick(1'b0, 1'b0, 8'h00, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.is_write) write_csr(row.index, row.value);
         else send_tick(row.lvl, row.req, row.data, row.typed, row.want);
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         items = 145;
         case (phase)
            3: begin
               period = 16'hFFFF;
               half   = 16'h7FFF;
               items  = 40;
            end
            7: begin
               period = 16'd0;
               half   = 16'd0;
            end
            9: begin
               period = 16'd1;
               half   = 16'd1;
            end
            default: begin
               period = tbut_pkg::PERIOD_W'($urandom_range(8, 2));
               half   = tbut_pkg::CSR_DATA_W'($urandom_range(period + 2, 0));
            end
         endcase
         write_csr(tbut_pkg::CSR_BIT_PERIOD, period);
         write_csr(tbut_pkg::CSR_HALF_BIT_PERIOD, half);
         if (phase == 5)
            write_csr(CSR_UNUSED_HI, tbut_pkg::CSR_DATA_W'($urandom_range(16'hFFFF, 0)));
         settings_used++;
         no_gaps   = (phase % 4 == 1);
         hold_long = (phase == 2);
         width     = (period <= 1) ? 1 : period;
         rx_pattern.delete();
         repeat (items) begin
            if (rx_pattern.size() == 0) queue_rx_pattern(width, period > 16);
            send_tick(rx_pattern.pop_front(), 1'($urandom_range(5, 0) == 0),
                      8'($urandom_range(255, 0)), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d tick words over %0d register settings.",
               words_sent, settings_used);
      $display("The transmitter took %0d frames and the receiver delivered %0d bytes.",
               frames_taken, bytes_seen);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* timer_based_uart_transceiver.f */
rtl/tbut_pkg.sv
rtl/tbut_tx.sv
rtl/tbut_rx.sv
rtl/timer_based_uart_transceiver.sv
test/timer_based_uart_transceiver_test.sv
